FILE: design/eqm_pkg.sv
// ---------------------------------------------------------------------------
// eqm_pkg
// Shared types and constants for the event fan-out queue manager.
// ---------------------------------------------------------------------------
package eqm_pkg;

    // Action codes
    localparam logic [2:0] ACT_PUBLISH = 3'd0;
    localparam logic [2:0] ACT_SET_INT = 3'd1;
    localparam logic [2:0] ACT_FETCH   = 3'd2;
    localparam logic [2:0] ACT_ATTACH  = 3'd3;
    localparam logic [2:0] ACT_DETACH  = 3'd4;

    // Event descriptor: kind, mask, size, payload
    localparam int EVT_W = 112;
    // Width used for the queue limit compare (covers the largest queue depth)
    localparam int LIM_W = 10;
    localparam logic [4:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic load;
        logic pub_step;
        logic att_step;
        logic set_int;
        logic detach;
        logic fetch_rd;
        logic fetch_pop;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       size_zero;
        logic       sub_ok;
        logic       fetch_ok;
        logic       scan_last;
        logic       slot_free;
    } t_stat;

endpackage

FILE: design/eqm_ram.sv
// ---------------------------------------------------------------------------
// eqm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module eqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/eqm_ctrl.sv
// ---------------------------------------------------------------------------
// eqm_ctrl
// Sequencer: decodes the action and steps the datapath through it.
// ---------------------------------------------------------------------------
module eqm_ctrl import eqm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output logic  o_done,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_PUB  = 3'd2;
    localparam logic [2:0] ST_ATT  = 3'd3;
    localparam logic [2:0] ST_FRD  = 3'd4;
    localparam logic [2:0] ST_FPOP = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_done;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DEC;
                end
            end
            ST_DEC: begin
                n_state = ST_FIN;
                unique case (i_stat.action)
                    ACT_PUBLISH: begin
                        if (!i_stat.size_zero) begin
                            n_state = ST_PUB;
                        end
                    end
                    ACT_SET_INT: o_cmd.set_int = i_stat.sub_ok;
                    ACT_FETCH: begin
                        if (i_stat.fetch_ok) begin
                            n_state = ST_FRD;
                        end
                    end
                    ACT_ATTACH: n_state = ST_ATT;
                    ACT_DETACH: o_cmd.detach = i_stat.sub_ok;
                    default: n_state = ST_FIN;
                endcase
            end
            ST_PUB: begin
                o_cmd.pub_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_ATT: begin
                o_cmd.att_step = 1'b1;
                if (i_stat.slot_free || i_stat.scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FRD: begin
                o_cmd.fetch_rd = 1'b1;
                n_state        = ST_FPOP;
            end
            ST_FPOP: begin
                o_cmd.fetch_pop = 1'b1;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_FIN);
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe longer than one cycle");
    a_start_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> (r_state == ST_DEC))
        else $error("accepted item not decoded");

endmodule

FILE: design/eqm_dp.sv
// ---------------------------------------------------------------------------
// eqm_dp
// Datapath: per-slot state, event store and result registers.
// ---------------------------------------------------------------------------
module eqm_dp import eqm_pkg::*; #(
    parameter int SUBSCRIBERS = 32,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_subscriber,
    input  logic [31:0] i_app_mask,
    input  logic [31:0] i_event_kind,
    input  logic [15:0] i_event_size,
    input  logic [31:0] i_payload_word,
    output logic        o_status,
    output logic [4:0]  o_slot_index,
    output logic [31:0] o_out_kind,
    output logic [31:0] o_out_mask,
    output logic [15:0] o_out_size,
    output logic [31:0] o_out_payload,
    output logic [4:0]  o_pending_count
);

    localparam int SW = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
    localparam int XW = (SW > 5) ? SW : 5;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(SUBSCRIBERS * QUEUE_DEPTH);

    logic [4:0]        r_limit;
    logic              r_used [SUBSCRIBERS];
    logic [31:0]       r_int  [SUBSCRIBERS];
    logic [CW-1:0]     r_cnt  [SUBSCRIBERS];
    logic [HW-1:0]     r_head [SUBSCRIBERS];

    logic [2:0]        r_action;
    logic [4:0]        r_sub;
    logic [31:0]       r_mask;
    logic [31:0]       r_kind;
    logic [15:0]       r_size;
    logic [31:0]       r_pay;
    logic              r_status;
    logic [XW-1:0]     r_slot;
    logic [EVT_W-1:0]  r_got;
    logic [SW-1:0]     r_idx;

    logic [SW-1:0]     sub_i;
    logic              sub_ok;
    logic [LIM_W-1:0]  lim_ext;
    logic [LIM_W-1:0]  lim_eff;
    logic              pub_hit;
    logic [CW:0]       pos_sum;
    logic [HW-1:0]     pos;
    logic [HW-1:0]     head_nx;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [EVT_W-1:0]  wdata;
    logic [EVT_W-1:0]  rdata;
    logic [SW-1:0]     slot_i;
    logic              slot_ok;

    // Effective queue limit saturates at the queue depth
    assign lim_ext = LIM_W'(r_limit);
    assign lim_eff = (lim_ext > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH) : lim_ext;

    // Requested slot
    assign sub_i  = SW'(r_sub);
    assign sub_ok = (7'(r_sub) < 7'(SUBSCRIBERS));

    // Publish: tail position of the scanned slot, wrapped once
    assign pub_hit = r_used[r_idx] && ((r_int[r_idx] & r_mask) != 32'd0)
                     && (LIM_W'(r_cnt[r_idx]) < lim_eff);
    assign pos_sum = (CW+1)'(r_head[r_idx]) + (CW+1)'(r_cnt[r_idx]);
    assign pos     = (pos_sum >= (CW+1)'(QUEUE_DEPTH))
                     ? HW'(pos_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
    assign waddr   = AW'(r_idx) * AW'(QUEUE_DEPTH) + AW'(pos);
    assign wdata   = {r_kind, r_mask, r_size, r_pay};

    // Fetch: head of the requested slot
    assign raddr   = AW'(sub_i) * AW'(QUEUE_DEPTH) + AW'(r_head[sub_i]);
    assign head_nx = (32'(r_head[sub_i]) == QUEUE_DEPTH - 1) ? '0 : r_head[sub_i] + 1'b1;

    eqm_ram #(
        .WIDTH (EVT_W),
        .DEPTH (SUBSCRIBERS * QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pub_step && pub_hit),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.fetch_rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Status to the sequencer
    always_comb begin
        o_stat.action    = r_action;
        o_stat.size_zero = (r_size == 16'd0);
        o_stat.sub_ok    = sub_ok && r_used[sub_i];
        o_stat.fetch_ok  = sub_ok && r_used[sub_i] && ((r_int[sub_i] & r_mask) != 32'd0)
                           && (r_cnt[sub_i] != '0);
        o_stat.scan_last = (r_idx == SW'(SUBSCRIBERS - 1));
        o_stat.slot_free = !r_used[r_idx];
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Per-slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SUBSCRIBERS; s++) begin
                r_used[s] <= 1'b0;
                r_int[s]  <= '0;
                r_cnt[s]  <= '0;
                r_head[s] <= '0;
            end
        end else begin
            if (i_cmd.pub_step && pub_hit) begin
                r_cnt[r_idx] <= r_cnt[r_idx] + 1'b1;
            end
            if (i_cmd.att_step && !r_used[r_idx]) begin
                r_used[r_idx] <= 1'b1;
                r_int[r_idx]  <= '0;
                r_cnt[r_idx]  <= '0;
                r_head[r_idx] <= '0;
            end
            if (i_cmd.set_int) begin
                r_int[sub_i] <= r_mask;
            end
            if (i_cmd.detach) begin
                r_used[sub_i] <= 1'b0;
                r_int[sub_i]  <= '0;
                r_cnt[sub_i]  <= '0;
                r_head[sub_i] <= '0;
            end
            if (i_cmd.fetch_pop) begin
                r_head[sub_i] <= head_nx;
                r_cnt[sub_i]  <= r_cnt[sub_i] - 1'b1;
            end
        end
    end

    // Control registers of the item in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_status <= 1'b1;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_status <= 1'b1;
            end
            if (i_cmd.pub_step || i_cmd.att_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if ((i_cmd.pub_step && pub_hit) || (i_cmd.att_step && !r_used[r_idx])
                || i_cmd.set_int || i_cmd.detach || i_cmd.fetch_pop) begin
                r_status <= 1'b0;
            end
        end
    end

    // Latch the item and collect the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_sub    <= i_subscriber;
            r_mask   <= i_app_mask;
            r_kind   <= i_event_kind;
            r_size   <= i_event_size;
            r_pay    <= i_payload_word;
            r_slot   <= XW'(i_subscriber);
            r_got    <= '0;
        end
        if (i_cmd.att_step && !r_used[r_idx]) begin
            r_slot <= XW'(r_idx);
        end
        if (i_cmd.fetch_pop) begin
            r_got <= rdata;
        end
    end

    // Output registers
    assign slot_i  = SW'(r_slot);
    assign slot_ok = ((XW+1)'(r_slot) < (XW+1)'(SUBSCRIBERS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_status        <= r_status;
            o_slot_index    <= 5'(r_slot);
            o_out_kind      <= r_got[111:80];
            o_out_mask      <= r_got[79:48];
            o_out_size      <= r_got[47:32];
            o_out_payload   <= r_got[31:0];
            o_pending_count <= slot_ok ? 5'(r_cnt[slot_i]) : 5'd0;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cnt[r_idx]) <= QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

FILE: design/event_fanout_queue_manager.sv
// ---------------------------------------------------------------------------
// event_fanout_queue_manager
// Publish-subscribe event router: subscriber slots with interest masks and
// per-slot event queues in a shared store.
//
//   channel  | direction | handshake                 | beat
//   ---------+-----------+---------------------------+------------------------
//   command  | in        | i_start high, o_busy low  | action, slot, event
//   result   | out       | o_done, one cycle         | status, slot, event, count
//   config   | in        | i_cfg_valid & o_cfg_ready | queue limit
//
// Publish visits one slot per cycle against the single write port of the
// event store; a zero-size event skips the scan. Attach scans the slots and
// stops at the first free slot. Fetch reads the store, then pops the queue
// head (registered store read). Reset is synchronous and clears all slot
// state at once. The receiver cannot stall; o_done is one cycle.
// ---------------------------------------------------------------------------
module event_fanout_queue_manager import eqm_pkg::*; #(
    parameter int SUBSCRIBERS = 32,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    output logic        o_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_subscriber,
    input  logic [31:0] i_app_mask,
    input  logic [31:0] i_event_kind,
    input  logic [15:0] i_event_size,
    input  logic [31:0] i_payload_word,
    output logic        o_status,
    output logic [4:0]  o_slot_index,
    output logic [31:0] o_out_kind,
    output logic [31:0] o_out_mask,
    output logic [15:0] o_out_size,
    output logic [31:0] o_out_payload,
    output logic [4:0]  o_pending_count
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    eqm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    eqm_dp #(
        .SUBSCRIBERS (SUBSCRIBERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_subscriber    (i_subscriber),
        .i_app_mask      (i_app_mask),
        .i_event_kind    (i_event_kind),
        .i_event_size    (i_event_size),
        .i_payload_word  (i_payload_word),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_out_kind      (o_out_kind),
        .o_out_mask      (o_out_mask),
        .o_out_size      (o_out_size),
        .o_out_payload   (o_out_payload),
        .o_pending_count (o_pending_count)
    );

endmodule
